// ===== rtl/cavp_pkg.sv =====
// Shared types, constants and codes for the cascaded angle/velocity PID block.
// Used by every module under rtl/; depends on nothing.
package cavp_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int VOLT_LIMIT     = 20000;
    localparam int SPEED_LIMIT    = 200;
    localparam int HALF_TURN      = 4096;

    localparam int NUM_REGS    = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam int ANGLE_W   = 32;
    localparam int RAW_W     = 13;
    localparam int TURN_W    = ANGLE_W - RAW_W;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 33;
    localparam int DIFF_W    = 34;
    localparam int OINTEG_W  = 48;
    localparam int IERR_W    = 18;
    localparam int IINTEG_W  = 40;
    localparam int OPND_W    = 48;
    localparam int CHUNK_W   = 24;
    localparam int MUL_A_W   = CFG_DATA_W + 1;
    localparam int MUL_B_W   = OPND_W - CHUNK_W + 1;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = 64;
    localparam int VOLT_W    = 16;

    localparam int MAC_STEPS  = 6;
    localparam int MAC_STEP_W = $clog2(MAC_STEPS);

    localparam logic signed [SUM_W-1:0] TERM_CEIL  = 64'sh2000_0000_0000_0000;
    localparam logic signed [SUM_W-1:0] TERM_FLOOR = -64'sh2000_0000_0000_0000;
    localparam logic [SUM_W-1:0] ROUND_HALF = 64'd1 << (GAIN_FRAC_BITS - 1);
    localparam logic [VOLT_W-1:0] VOLT_LIM  = VOLT_W'(VOLT_LIMIT);
    localparam logic [VOLT_W-1:0] SPEED_LIM = VOLT_W'(SPEED_LIMIT);

    localparam logic [CFG_DATA_W-1:0] OUTER_KP_RESET = 16'd3840;
    localparam logic [CFG_DATA_W-1:0] OUTER_KI_RESET = 16'd64;
    localparam logic [CFG_DATA_W-1:0] OUTER_KD_RESET = 16'd0;
    localparam logic [CFG_DATA_W-1:0] INNER_KP_RESET = 16'd3840;
    localparam logic [CFG_DATA_W-1:0] INNER_KI_RESET = 16'd64;
    localparam logic [CFG_DATA_W-1:0] INNER_KD_RESET = 16'd0;
    localparam logic [CFG_DATA_W-1:0] DEAD_ENTER_RESET = 16'd500;
    localparam logic [CFG_DATA_W-1:0] DEAD_EXIT_RESET  = 16'd600;

    typedef enum logic [2:0] {
        REG_OUTER_KP,
        REG_OUTER_KI,
        REG_OUTER_KD,
        REG_INNER_KP,
        REG_INNER_KI,
        REG_INNER_KD,
        REG_DEAD_ENTER,
        REG_DEAD_EXIT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TERM_PROP,
        TERM_INTEG,
        TERM_DERIV
    } mac_term_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOLD,
        ST_OMAC,
        ST_ODRAIN,
        ST_ORND1,
        ST_ORND2,
        ST_IERR,
        ST_IUPD,
        ST_IMAC,
        ST_IDRAIN,
        ST_IRND1,
        ST_IRND2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                      mode;
        logic [RAW_W-1:0]          enc_angle;
        logic signed [SPEED_W-1:0] measured_speed;
        logic signed [ANGLE_W-1:0] target_angle;
    } item_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0]  drive_voltage;
        logic                      holding;
        logic signed [ANGLE_W-1:0] unwrapped_angle;
    } result_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] outer_prop_gain;
        logic [CFG_DATA_W-1:0] outer_integ_gain;
        logic [CFG_DATA_W-1:0] outer_deriv_gain;
        logic [CFG_DATA_W-1:0] inner_prop_gain;
        logic [CFG_DATA_W-1:0] inner_integ_gain;
        logic [CFG_DATA_W-1:0] inner_deriv_gain;
        logic [CFG_DATA_W-1:0] dead_enter_ticks;
        logic [CFG_DATA_W-1:0] dead_exit_ticks;
    } cfg_t;

    typedef struct packed {
        logic      load_item;
        logic      hold_eval;
        logic      sum_clr;
        logic      mac_issue;
        logic      mac_inner;
        mac_term_t mac_term;
        logic      mac_hi;
        logic      rnd_first;
        logic      rnd_final;
        logic      rnd_inner;
        logic      inner_err;
        logic      inner_upd;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic hold_next;
        logic mac_busy;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/cavp_cfg.sv =====
// Configuration register file: gains and deadband thresholds.
// Depends on cavp_pkg.
module cavp_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cavp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cavp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output cavp_pkg::cfg_t                       cfg
);

    cavp_pkg::cfg_t cfg_reg;
    cavp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en && (int'(cfg_index) < cavp_pkg::NUM_REGS))
        begin
            unique case (cavp_pkg::cfg_reg_t'(cfg_index[2:0]))
                cavp_pkg::REG_OUTER_KP:   cfg_next.outer_prop_gain  = cfg_data;
                cavp_pkg::REG_OUTER_KI:   cfg_next.outer_integ_gain = cfg_data;
                cavp_pkg::REG_OUTER_KD:   cfg_next.outer_deriv_gain = cfg_data;
                cavp_pkg::REG_INNER_KP:   cfg_next.inner_prop_gain  = cfg_data;
                cavp_pkg::REG_INNER_KI:   cfg_next.inner_integ_gain = cfg_data;
                cavp_pkg::REG_INNER_KD:   cfg_next.inner_deriv_gain = cfg_data;
                cavp_pkg::REG_DEAD_ENTER: cfg_next.dead_enter_ticks = cfg_data;
                cavp_pkg::REG_DEAD_EXIT:  cfg_next.dead_exit_ticks  = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outer_prop_gain  <= cavp_pkg::OUTER_KP_RESET;
            cfg_reg.outer_integ_gain <= cavp_pkg::OUTER_KI_RESET;
            cfg_reg.outer_deriv_gain <= cavp_pkg::OUTER_KD_RESET;
            cfg_reg.inner_prop_gain  <= cavp_pkg::INNER_KP_RESET;
            cfg_reg.inner_integ_gain <= cavp_pkg::INNER_KI_RESET;
            cfg_reg.inner_deriv_gain <= cavp_pkg::INNER_KD_RESET;
            cfg_reg.dead_enter_ticks <= cavp_pkg::DEAD_ENTER_RESET;
            cfg_reg.dead_exit_ticks  <= cavp_pkg::DEAD_EXIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/cavp_ctrl.sv =====
// Sequencer for the PID block: accepts items and steps the datapath.
// Depends on cavp_pkg; drives cavp_dp through cmd_t and reads status_t.
module cavp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_mode,
    output logic                item_stall,
    input  cavp_pkg::status_t   status,
    output cavp_pkg::cmd_t      cmd
);

    cavp_pkg::state_t                    state_reg;
    cavp_pkg::state_t                    state_next;
    logic [cavp_pkg::MAC_STEP_W-1:0]     step_reg;
    logic [cavp_pkg::MAC_STEP_W-1:0]     step_next;
    logic                                step_last;

    assign step_last = (step_reg == cavp_pkg::MAC_STEP_W'(cavp_pkg::MAC_STEPS - 1));

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.mac_term = cavp_pkg::mac_term_t'(step_reg[cavp_pkg::MAC_STEP_W-1:1]);
        cmd.mac_hi   = step_reg[0];
        item_stall   = 1'b1;
        unique case (state_reg)
            cavp_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (item_mode)
                        state_next = cavp_pkg::ST_HOLD;
                end
            end
            cavp_pkg::ST_HOLD:
            begin
                cmd.hold_eval = 1'b1;
                cmd.sum_clr   = 1'b1;
                step_next     = '0;
                state_next    = status.hold_next ? cavp_pkg::ST_OUT : cavp_pkg::ST_OMAC;
            end
            cavp_pkg::ST_OMAC:
            begin
                cmd.mac_issue = 1'b1;
                step_next     = step_last ? '0 : step_reg + 1'b1;
                if (step_last)
                    state_next = cavp_pkg::ST_ODRAIN;
            end
            cavp_pkg::ST_ODRAIN:
            begin
                if (!status.mac_busy)
                    state_next = cavp_pkg::ST_ORND1;
            end
            cavp_pkg::ST_ORND1:
            begin
                cmd.rnd_first = 1'b1;
                state_next    = cavp_pkg::ST_ORND2;
            end
            cavp_pkg::ST_ORND2:
            begin
                cmd.rnd_final = 1'b1;
                state_next    = cavp_pkg::ST_IERR;
            end
            cavp_pkg::ST_IERR:
            begin
                cmd.inner_err = 1'b1;
                state_next    = cavp_pkg::ST_IUPD;
            end
            cavp_pkg::ST_IUPD:
            begin
                cmd.inner_upd = 1'b1;
                cmd.sum_clr   = 1'b1;
                step_next     = '0;
                state_next    = cavp_pkg::ST_IMAC;
            end
            cavp_pkg::ST_IMAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_inner = 1'b1;
                step_next     = step_last ? '0 : step_reg + 1'b1;
                if (step_last)
                    state_next = cavp_pkg::ST_IDRAIN;
            end
            cavp_pkg::ST_IDRAIN:
            begin
                if (!status.mac_busy)
                    state_next = cavp_pkg::ST_IRND1;
            end
            cavp_pkg::ST_IRND1:
            begin
                cmd.rnd_first = 1'b1;
                state_next    = cavp_pkg::ST_IRND2;
            end
            cavp_pkg::ST_IRND2:
            begin
                cmd.rnd_final = 1'b1;
                cmd.rnd_inner = 1'b1;
                state_next    = cavp_pkg::ST_OUT;
            end
            cavp_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cavp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cavp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cavp_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/cavp_dp.sv =====
// Datapath: angle unwrap, loop state, shared multiply-accumulate, rounding,
// result register. Depends on cavp_pkg; commanded by cavp_ctrl.
module cavp_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cavp_pkg::item_t      item_data,
    input  cavp_pkg::cfg_t       cfg,
    input  cavp_pkg::cmd_t       cmd,
    output cavp_pkg::status_t    status,
    output logic                 result_valid,
    input  logic                 result_stall,
    output cavp_pkg::result_t    result_data
);

    // loop state
    logic signed [cavp_pkg::TURN_W-1:0]   turn_reg, turn_next;
    logic [cavp_pkg::RAW_W-1:0]           last_raw_reg, last_raw_next;
    logic                                 have_raw_reg, have_raw_next;
    logic signed [cavp_pkg::SPEED_W-1:0]  speed_reg, speed_next;
    logic                                 hold_reg, hold_next;
    logic signed [cavp_pkg::OINTEG_W-1:0] ointeg_reg, ointeg_next;
    logic signed [cavp_pkg::ERR_W-1:0]    olast_reg, olast_next;
    logic signed [cavp_pkg::IINTEG_W-1:0] iinteg_reg, iinteg_next;
    logic signed [cavp_pkg::IERR_W-1:0]   ilast_reg, ilast_next;

    // working registers
    logic signed [cavp_pkg::ERR_W-1:0]    err_reg, err_next;
    logic signed [cavp_pkg::DIFF_W-1:0]   diff_reg, diff_next;
    logic signed [cavp_pkg::MUL_P_W-1:0]  prod_reg, prod_next;
    logic                                 pv_reg, pv_next;
    logic                                 phi_reg, phi_next;
    logic                                 tdone_reg, tdone_next;
    logic signed [cavp_pkg::SUM_W-1:0]    term_reg, term_next;
    logic signed [cavp_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [cavp_pkg::SUM_W-1:0]           rmag_reg, rmag_next;
    logic                                 rsign_reg, rsign_next;
    logic signed [cavp_pkg::VOLT_W-1:0]   rnd_reg, rnd_next;
    logic                                 res_valid_reg, res_valid_next;
    cavp_pkg::result_t                    res_reg, res_next;

    logic signed [cavp_pkg::ANGLE_W-1:0]  angle;
    logic signed [cavp_pkg::RAW_W:0]      raw_diff;
    logic [cavp_pkg::ERR_W-1:0]           err_mag;
    logic                                 hold_eval_next;
    logic signed [cavp_pkg::OINTEG_W:0]   osum;
    logic signed [cavp_pkg::IINTEG_W:0]   isum;
    logic signed [cavp_pkg::OPND_W-1:0]   opnd;
    logic [cavp_pkg::CFG_DATA_W-1:0]      gain;
    logic signed [cavp_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [cavp_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [cavp_pkg::SUM_W-1:0]    prod_ext;
    logic signed [cavp_pkg::SUM_W-1:0]    term_clip;
    logic [cavp_pkg::VOLT_W-1:0]          rnd_lim;
    logic [cavp_pkg::VOLT_W-1:0]          rnd_clip;
    logic signed [cavp_pkg::ERR_W-1:0]    ierr_full;

    assign angle    = {turn_reg, last_raw_reg};
    assign raw_diff = $signed({1'b0, item_data.enc_angle}) - $signed({1'b0, last_raw_reg});
    assign err_mag  = err_reg[cavp_pkg::ERR_W-1] ? cavp_pkg::ERR_W'(-err_reg)
                                                 : cavp_pkg::ERR_W'(err_reg);

    assign hold_eval_next = hold_reg
        ? !(err_mag > {{(cavp_pkg::ERR_W-cavp_pkg::CFG_DATA_W){1'b0}}, cfg.dead_exit_ticks})
        :  (err_mag < {{(cavp_pkg::ERR_W-cavp_pkg::CFG_DATA_W){1'b0}}, cfg.dead_enter_ticks});

    assign osum = {ointeg_reg[cavp_pkg::OINTEG_W-1], ointeg_reg}
                + {{(cavp_pkg::OINTEG_W+1-cavp_pkg::ERR_W){err_reg[cavp_pkg::ERR_W-1]}},
                   err_reg};
    assign isum = {iinteg_reg[cavp_pkg::IINTEG_W-1], iinteg_reg}
                + {{(cavp_pkg::IINTEG_W+1-cavp_pkg::IERR_W){err_reg[cavp_pkg::IERR_W-1]}},
                   err_reg[cavp_pkg::IERR_W-1:0]};

    assign ierr_full = {{(cavp_pkg::ERR_W-cavp_pkg::VOLT_W){rnd_reg[cavp_pkg::VOLT_W-1]}},
                        rnd_reg}
                     - {{(cavp_pkg::ERR_W-cavp_pkg::SPEED_W){speed_reg[cavp_pkg::SPEED_W-1]}},
                        speed_reg};

    // operand and gain select for the shared multiplier
    always_comb
    begin
        case (cmd.mac_term)
            cavp_pkg::TERM_PROP:
            begin
                opnd = {{(cavp_pkg::OPND_W-cavp_pkg::ERR_W){err_reg[cavp_pkg::ERR_W-1]}},
                        err_reg};
                gain = cmd.mac_inner ? cfg.inner_prop_gain : cfg.outer_prop_gain;
            end
            cavp_pkg::TERM_INTEG:
            begin
                opnd = cmd.mac_inner
                     ? {{(cavp_pkg::OPND_W-cavp_pkg::IINTEG_W){iinteg_reg[cavp_pkg::IINTEG_W-1]}},
                        iinteg_reg}
                     : ointeg_reg;
                gain = cmd.mac_inner ? cfg.inner_integ_gain : cfg.outer_integ_gain;
            end
            cavp_pkg::TERM_DERIV:
            begin
                opnd = {{(cavp_pkg::OPND_W-cavp_pkg::DIFF_W){diff_reg[cavp_pkg::DIFF_W-1]}},
                        diff_reg};
                gain = cmd.mac_inner ? cfg.inner_deriv_gain : cfg.outer_deriv_gain;
            end
            default:
            begin
                opnd = '0;
                gain = '0;
            end
        endcase
    end

    assign mul_a = {1'b0, gain};
    assign mul_b = cmd.mac_hi
                 ? {opnd[cavp_pkg::OPND_W-1], opnd[cavp_pkg::OPND_W-1:cavp_pkg::CHUNK_W]}
                 : {{(cavp_pkg::MUL_B_W-cavp_pkg::CHUNK_W){1'b0}},
                    opnd[cavp_pkg::CHUNK_W-1:0]};
    assign prod_next = mul_a * mul_b;

    assign prod_ext = {{(cavp_pkg::SUM_W-cavp_pkg::MUL_P_W){prod_reg[cavp_pkg::MUL_P_W-1]}},
                       prod_reg};

    assign term_clip = (term_reg > cavp_pkg::TERM_CEIL)  ? cavp_pkg::TERM_CEIL  :
                       (term_reg < cavp_pkg::TERM_FLOOR) ? cavp_pkg::TERM_FLOOR : term_reg;

    assign rnd_lim  = cmd.rnd_inner ? cavp_pkg::VOLT_LIM : cavp_pkg::SPEED_LIM;
    assign rnd_clip = (rmag_reg > {{(cavp_pkg::SUM_W-cavp_pkg::VOLT_W){1'b0}}, rnd_lim})
                    ? rnd_lim : rmag_reg[cavp_pkg::VOLT_W-1:0];

    always_comb
    begin
        turn_next      = turn_reg;
        last_raw_next  = last_raw_reg;
        have_raw_next  = have_raw_reg;
        speed_next     = speed_reg;
        hold_next      = hold_reg;
        ointeg_next    = ointeg_reg;
        olast_next     = olast_reg;
        iinteg_next    = iinteg_reg;
        ilast_next     = ilast_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        pv_next        = cmd.mac_issue;
        phi_next       = cmd.mac_hi;
        tdone_next     = pv_reg && phi_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        rmag_next      = rmag_reg;
        rsign_next     = rsign_reg;
        rnd_next       = rnd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;

        if (cmd.load_item)
        begin
            if (item_data.mode)
            begin
                err_next = {item_data.target_angle[cavp_pkg::ANGLE_W-1],
                            item_data.target_angle}
                         - {angle[cavp_pkg::ANGLE_W-1], angle};
            end
            else
            begin
                if (!have_raw_reg)
                    turn_next = '0;
                else if (raw_diff > $signed((cavp_pkg::RAW_W+1)'(cavp_pkg::HALF_TURN)))
                    turn_next = turn_reg - 1'b1;
                else if (raw_diff < -$signed((cavp_pkg::RAW_W+1)'(cavp_pkg::HALF_TURN)))
                    turn_next = turn_reg + 1'b1;
                have_raw_next = 1'b1;
                last_raw_next = item_data.enc_angle;
                speed_next    = item_data.measured_speed;
            end
        end

        if (cmd.hold_eval)
        begin
            hold_next  = hold_eval_next;
            olast_next = err_reg;
            if (hold_eval_next)
            begin
                ointeg_next = '0;
                iinteg_next = '0;
                ilast_next  = '0;
            end
            else
            begin
                if (osum[cavp_pkg::OINTEG_W] != osum[cavp_pkg::OINTEG_W-1])
                    ointeg_next = {osum[cavp_pkg::OINTEG_W],
                                   {(cavp_pkg::OINTEG_W-1){~osum[cavp_pkg::OINTEG_W]}}};
                else
                    ointeg_next = osum[cavp_pkg::OINTEG_W-1:0];
                diff_next = {err_reg[cavp_pkg::ERR_W-1], err_reg}
                          - {olast_reg[cavp_pkg::ERR_W-1], olast_reg};
            end
        end

        if (cmd.inner_err)
            err_next = ierr_full;

        if (cmd.inner_upd)
        begin
            if (isum[cavp_pkg::IINTEG_W] != isum[cavp_pkg::IINTEG_W-1])
                iinteg_next = {isum[cavp_pkg::IINTEG_W],
                               {(cavp_pkg::IINTEG_W-1){~isum[cavp_pkg::IINTEG_W]}}};
            else
                iinteg_next = isum[cavp_pkg::IINTEG_W-1:0];
            diff_next = {{(cavp_pkg::DIFF_W-cavp_pkg::IERR_W){err_reg[cavp_pkg::IERR_W-1]}},
                         err_reg[cavp_pkg::IERR_W-1:0]}
                      - {{(cavp_pkg::DIFF_W-cavp_pkg::IERR_W){ilast_reg[cavp_pkg::IERR_W-1]}},
                         ilast_reg};
            ilast_next = err_reg[cavp_pkg::IERR_W-1:0];
        end

        // term assembly: low chunk loads, high chunk adds shifted
        if (pv_reg)
        begin
            if (phi_reg)
                term_next = term_reg + (prod_ext <<< cavp_pkg::CHUNK_W);
            else
                term_next = prod_ext;
        end

        if (cmd.sum_clr)
            sum_next = '0;
        else if (tdone_reg)
            sum_next = sum_reg + term_clip;

        if (cmd.rnd_first)
        begin
            rsign_next = sum_reg[cavp_pkg::SUM_W-1];
            if (sum_reg[cavp_pkg::SUM_W-1])
                rmag_next = (cavp_pkg::ROUND_HALF - cavp_pkg::SUM_W'(sum_reg))
                            >> cavp_pkg::GAIN_FRAC_BITS;
            else
                rmag_next = (cavp_pkg::SUM_W'(sum_reg) + cavp_pkg::ROUND_HALF)
                            >> cavp_pkg::GAIN_FRAC_BITS;
        end

        if (cmd.rnd_final)
            rnd_next = rsign_reg ? -$signed(rnd_clip) : $signed(rnd_clip);

        if (cmd.out_load)
        begin
            res_valid_next           = 1'b1;
            res_next.drive_voltage   = hold_reg ? '0 : rnd_reg;
            res_next.holding         = hold_reg;
            res_next.unwrapped_angle = angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg      <= '0;
            last_raw_reg  <= '0;
            have_raw_reg  <= 1'b0;
            speed_reg     <= '0;
            hold_reg      <= 1'b0;
            ointeg_reg    <= '0;
            olast_reg     <= '0;
            iinteg_reg    <= '0;
            ilast_reg     <= '0;
            pv_reg        <= 1'b0;
            phi_reg       <= 1'b0;
            tdone_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            turn_reg      <= turn_next;
            last_raw_reg  <= last_raw_next;
            have_raw_reg  <= have_raw_next;
            speed_reg     <= speed_next;
            hold_reg      <= hold_next;
            ointeg_reg    <= ointeg_next;
            olast_reg     <= olast_next;
            iinteg_reg    <= iinteg_next;
            ilast_reg     <= ilast_next;
            pv_reg        <= pv_next;
            phi_reg       <= phi_next;
            tdone_reg     <= tdone_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        term_reg  <= term_next;
        sum_reg   <= sum_next;
        rmag_reg  <= rmag_next;
        rsign_reg <= rsign_next;
        rnd_reg   <= rnd_next;
        res_reg   <= res_next;
    end

    assign status.hold_next = hold_eval_next;
    assign status.mac_busy  = pv_reg || tdone_reg;
    assign status.out_free  = !res_valid_reg || !result_stall;

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

endmodule

// ===== rtl/cascaded_angle_velocity_pid.sv =====
// Cascaded angle/speed PID controller, top level.
// Depends on cavp_pkg, cavp_cfg, cavp_ctrl and cavp_dp.
//
// Feedback beats (mode 0) unwrap the 13-bit encoder angle into a multi-turn
// count and store the measured speed; they give no result. Control ticks
// (mode 1) run the angle loop then the speed loop, or skip both when the
// tick holds position, and give one result beat. The loops share a single
// 17x25 signed multiplier that makes two passes for each of the six gain
// products, feeding a three-stage multiply, assemble and accumulate pipeline.
// A result waits in an output register; a tick that finishes while it is
// still stalled holds until it is taken. Items are taken one at a time.
module cascaded_angle_velocity_pid (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cavp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cavp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  cavp_pkg::item_t                    item_data,
    output logic                               result_valid,
    input  logic                               result_stall,
    output cavp_pkg::result_t                  result_data
);

    cavp_pkg::cfg_t    cfg;
    cavp_pkg::cmd_t    cmd;
    cavp_pkg::status_t status;

    cavp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cavp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item_data.mode),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    cavp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_data    (item_data),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
